[hdl/bltm_pkg.sv]
package bltm_pkg;

    // Widths fixed by the word fields.
    localparam int PC_W    = 13;
    localparam int CADDR_W = 12;
    localparam int DP_W    = 12;

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Instruction characters.
    localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

    typedef enum logic [2:0] {
        RUN_IDLE      = 3'd0,
        RUN_ACTIVE    = 3'd1,
        RUN_DONE      = 3'd2,
        RUN_OVF       = 3'd3,
        RUN_NEG       = 3'd4,
        RUN_UNMATCHED = 3'd5
    } t_run;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CLEAR,
        S_RESULT
    } t_state;

endpackage

[hdl/bltm_prog_store.sv]
module bltm_prog_store #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    // Program characters, one read and one write port, registered read.
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bltm_tape.sv]
module bltm_tape #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    // Tape cells, one read and one write port, registered read.
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bracket_loop_tape_machine_unit.sv]
// Eight-instruction tape machine. Each accepted word carries one command: load writes a
// program character (the one marked last sets the program length, rewinds the program
// counter and starts the machine), step executes the instruction at the program counter,
// and clear zeroes the tape and pointer. Every word produces exactly one result word with
// the output byte, the run status, the pointer and the program counter. A step reads the
// program store and the current tape cell, then decodes the instruction and writes the
// cell back. A taken bracket jump then scans the program characters, streaming the program
// store one address a cycle. Clearing the tape, by command, by an unmatched bracket, or
// after reset, sweeps the tape memory one cell a cycle, during which no word is accepted.
// A finished result sits in an output register, so the next word is accepted while it
// waits to be taken.
module bracket_loop_tape_machine_unit #(
    parameter int TAPE_CELLS    = 4096,
    parameter int PROGRAM_DEPTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_command,
    input  logic [bltm_pkg::CADDR_W-1:0]  i_code_address,
    input  logic [7:0]                    i_code_char,
    input  logic                          i_code_last,
    input  logic [7:0]                    i_input_byte,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_out_valid,
    output logic [7:0]                    o_out_byte,
    output logic [2:0]                    o_status,
    output logic [bltm_pkg::DP_W-1:0]     o_data_pointer,
    output logic [bltm_pkg::PC_W-1:0]     o_program_counter
);

    import bltm_pkg::*;

    localparam int TW = $clog2(TAPE_CELLS);
    localparam int PW = $clog2(PROGRAM_DEPTH);

    // Control state.
    t_state          r_state, n_state;
    t_run            r_run, n_run;
    logic [TW-1:0]   r_ptr, n_ptr;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [PC_W-1:0] r_len, n_len;
    logic [TW-1:0]   r_clr_cnt, n_clr_cnt;
    logic            r_clr_res, n_clr_res;
    logic            r_chk_valid, n_chk_valid;

    // Bracket scan and per-word payload.
    logic [PC_W-1:0] r_nest, n_nest;
    logic [PC_W-1:0] r_cur, n_cur;
    logic [PC_W-1:0] r_chk_addr, n_chk_addr;
    logic            r_fwd, n_fwd;
    logic [7:0]      r_inb, n_inb;
    logic            r_res_ov, n_res_ov;
    logic [7:0]      r_res_ob, n_res_ob;

    // Output register.
    logic            r_o_valid;
    logic            r_o_out_valid;
    logic [7:0]      r_o_out_byte;
    logic [2:0]      r_o_status;
    logic [DP_W-1:0] r_o_dp;
    logic [PC_W-1:0] r_o_pc;

    // Memory ports.
    logic            w_pm_we;
    logic [PW-1:0]   w_pm_raddr;
    logic [7:0]      w_pm_rdata;
    logic            w_tp_we;
    logic [TW-1:0]   w_tp_waddr;
    logic [7:0]      w_tp_wdata;
    logic [7:0]      w_tp_rdata;

    // Decisions shared by the next-state and datapath logic.
    logic            w_finish;
    logic            w_enter_exec;
    logic            w_enter_scan;
    logic            w_enter_clear;
    logic            w_adv;
    logic            w_out_free;
    logic            w_out_load;

    logic            w_load_ok;
    logic [PC_W-1:0] w_pc_inc;
    logic [PC_W-1:0] w_hit_pc;
    logic [PC_W-1:0] w_issue;
    logic [PC_W-1:0] w_nest_upd;
    logic [7:0]      w_open;
    logic [7:0]      w_close;
    logic            w_scan_hit;
    logic            w_scan_end;
    logic            w_clr_last;

    // The program store holds characters as loaded; the tape holds the cells.
    bltm_prog_store #(
        .DEPTH (PROGRAM_DEPTH)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (w_pm_we),
        .i_waddr (PW'(i_code_address)),
        .i_wdata (i_code_char),
        .i_raddr (w_pm_raddr),
        .o_rdata (w_pm_rdata)
    );

    bltm_tape #(
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (w_tp_we),
        .i_waddr (w_tp_waddr),
        .i_wdata (w_tp_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_tp_rdata)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_out_load = w_finish && w_out_free;

    assign w_load_ok = 32'(i_code_address) < PROGRAM_DEPTH;
    assign w_pc_inc  = r_pc + PC_W'(1);
    assign w_hit_pc  = r_chk_addr + PC_W'(1);

    // The scan cursor follows the last address issued. Data for the address issued in one
    // cycle arrives in the next, so the nesting count lags the cursor by one character.
    assign w_open     = r_fwd ? CH_OPEN : CH_CLOSE;
    assign w_close    = r_fwd ? CH_CLOSE : CH_OPEN;
    assign w_issue    = r_fwd ? (r_cur + PC_W'(1)) : (r_cur - PC_W'(1));
    assign w_scan_end = r_fwd ? ((r_cur + PC_W'(1)) >= r_len) : (r_cur == '0);
    assign w_nest_upd = (w_pm_rdata == w_open)  ? (r_nest + PC_W'(1)) :
                        (w_pm_rdata == w_close) ? (r_nest - PC_W'(1)) : r_nest;
    assign w_scan_hit = r_chk_valid && (w_nest_upd == '0);

    assign w_clr_last = (r_clr_cnt == TW'(TAPE_CELLS - 1));

    // While idle the program store is read at the program counter, so its data is ready
    // in the execute cycle; during a scan it streams the issued addresses.
    assign w_pm_raddr = (r_state == S_SCAN) ? PW'(w_issue) : PW'(r_pc);

    // Next state.
    always_comb begin
        n_state = r_state;
        if (w_finish) begin
            n_state = w_out_free ? S_IDLE : S_RESULT;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_enter_exec) begin
                        n_state = S_EXEC;
                    end else if (w_enter_clear) begin
                        n_state = S_CLEAR;
                    end
                end
                S_EXEC: begin
                    if (w_enter_scan) begin
                        n_state = S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_enter_clear) begin
                        n_state = S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (w_clr_last) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    // Datapath and memory controls.
    always_comb begin
        n_run         = r_run;
        n_ptr         = r_ptr;
        n_pc          = r_pc;
        n_len         = r_len;
        n_clr_cnt     = r_clr_cnt;
        n_clr_res     = r_clr_res;
        n_chk_valid   = r_chk_valid;
        n_nest        = r_nest;
        n_cur         = r_cur;
        n_chk_addr    = r_chk_addr;
        n_fwd         = r_fwd;
        n_inb         = r_inb;
        n_res_ov      = r_res_ov;
        n_res_ob      = r_res_ob;
        w_finish      = 1'b0;
        w_enter_exec  = 1'b0;
        w_enter_scan  = 1'b0;
        w_enter_clear = 1'b0;
        w_adv         = 1'b0;
        w_pm_we       = 1'b0;
        w_tp_we       = 1'b0;
        w_tp_waddr    = r_ptr;
        w_tp_wdata    = 8'h00;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res_ov = 1'b0;
                    n_res_ob = 8'h00;
                    n_inb    = i_input_byte;
                    case (i_command)
                        CMD_LOAD: begin
                            w_finish = 1'b1;
                            if (w_load_ok) begin
                                w_pm_we = 1'b1;
                                if (i_code_last) begin
                                    n_len = PC_W'(i_code_address) + PC_W'(1);
                                    n_pc  = '0;
                                    n_run = RUN_ACTIVE;
                                end
                            end
                        end
                        CMD_STEP: begin
                            if ((r_run == RUN_ACTIVE) && (r_pc < r_len)) begin
                                w_enter_exec = 1'b1;
                            end else begin
                                w_finish = 1'b1;
                                if (r_run == RUN_ACTIVE) begin
                                    n_run = RUN_DONE;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_ptr         = '0;
                            n_clr_cnt     = '0;
                            n_clr_res     = 1'b1;
                            w_enter_clear = 1'b1;
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
            end

            S_EXEC: begin
                w_finish = 1'b1;
                w_adv    = 1'b1;
                case (w_pm_rdata)
                    CH_RIGHT: begin
                        if (r_ptr == TW'(TAPE_CELLS - 1)) begin
                            n_run = RUN_OVF;
                            w_adv = 1'b0;
                        end else begin
                            n_ptr = r_ptr + TW'(1);
                        end
                    end
                    CH_LEFT: begin
                        if (r_ptr == '0) begin
                            n_run = RUN_NEG;
                            w_adv = 1'b0;
                        end else begin
                            n_ptr = r_ptr - TW'(1);
                        end
                    end
                    CH_PLUS: begin
                        w_tp_we    = 1'b1;
                        w_tp_wdata = w_tp_rdata + 8'd1;
                    end
                    CH_MINUS: begin
                        w_tp_we    = 1'b1;
                        w_tp_wdata = w_tp_rdata - 8'd1;
                    end
                    CH_COMMA: begin
                        w_tp_we    = 1'b1;
                        w_tp_wdata = r_inb;
                    end
                    CH_DOT: begin
                        n_res_ov = 1'b1;
                        n_res_ob = w_tp_rdata;
                    end
                    CH_OPEN: begin
                        if (w_tp_rdata == 8'h00) begin
                            w_finish     = 1'b0;
                            w_adv        = 1'b0;
                            w_enter_scan = 1'b1;
                            n_fwd        = 1'b1;
                            n_cur        = r_pc;
                            n_chk_valid  = 1'b0;
                            n_nest       = PC_W'(1);
                        end
                    end
                    CH_CLOSE: begin
                        if (w_tp_rdata != 8'h00) begin
                            w_finish     = 1'b0;
                            w_adv        = 1'b0;
                            w_enter_scan = 1'b1;
                            n_fwd        = 1'b0;
                            n_cur        = r_pc;
                            n_chk_valid  = 1'b0;
                            n_nest       = PC_W'(1);
                        end
                    end
                    default: begin
                        w_adv = 1'b1;
                    end
                endcase
                if (w_adv) begin
                    n_pc = w_pc_inc;
                    if (w_pc_inc >= r_len) begin
                        n_run = RUN_DONE;
                    end
                end
            end

            S_SCAN: begin
                if (r_chk_valid) begin
                    n_nest = w_nest_upd;
                end
                if (w_scan_hit) begin
                    w_finish = 1'b1;
                    n_pc     = w_hit_pc;
                    if (w_hit_pc >= r_len) begin
                        n_run = RUN_DONE;
                    end
                end else if (!w_scan_end) begin
                    n_cur       = w_issue;
                    n_chk_valid = 1'b1;
                    n_chk_addr  = w_issue;
                end else begin
                    // Every issued character has been checked without a match.
                    n_ptr         = '0;
                    n_run         = RUN_UNMATCHED;
                    n_clr_cnt     = '0;
                    n_clr_res     = 1'b1;
                    w_enter_clear = 1'b1;
                end
            end

            S_CLEAR: begin
                w_tp_we    = 1'b1;
                w_tp_waddr = r_clr_cnt;
                w_tp_wdata = 8'h00;
                if (w_clr_last) begin
                    w_finish = r_clr_res;
                end else begin
                    n_clr_cnt = r_clr_cnt + TW'(1);
                end
            end

            S_RESULT: begin
                w_finish = 1'b1;
            end

            default: begin
                w_finish = 1'b0;
            end
        endcase
    end

    // Control registers. Reset starts a sweep that zeroes the tape with no result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_run       <= RUN_IDLE;
            r_ptr       <= '0;
            r_pc        <= '0;
            r_len       <= '0;
            r_clr_cnt   <= '0;
            r_clr_res   <= 1'b0;
            r_chk_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_ptr       <= n_ptr;
            r_pc        <= n_pc;
            r_len       <= n_len;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_res   <= n_clr_res;
            r_chk_valid <= n_chk_valid;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_nest     <= n_nest;
        r_cur      <= n_cur;
        r_chk_addr <= n_chk_addr;
        r_fwd      <= n_fwd;
        r_inb      <= n_inb;
        r_res_ov   <= n_res_ov;
        r_res_ob   <= n_res_ob;
        if (w_out_load) begin
            r_o_out_valid <= n_res_ov;
            r_o_out_byte  <= n_res_ov ? n_res_ob : 8'h00;
            r_o_status    <= n_run;
            r_o_dp        <= DP_W'(n_ptr);
            r_o_pc        <= n_pc;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_out_valid       = r_o_out_valid;
    assign o_out_byte        = r_o_out_byte;
    assign o_status          = r_o_status;
    assign o_data_pointer    = r_o_dp;
    assign o_program_counter = r_o_pc;

endmodule
